// File: design/epc_pkg.sv
package epc_pkg;

  localparam int MAX_PORTS = 8;
  localparam int MAX_ACTIVE = (MAX_PORTS < 8) ? MAX_PORTS : 8;
  localparam int PORT_W = $clog2(MAX_PORTS);
  localparam int CNT_W = $clog2(MAX_PORTS + 1);

  localparam int NCNT = 8;
  localparam int CTR_W = 32;
  localparam int ROW_W = NCNT * CTR_W;

  localparam int C_ALL = 0;
  localparam int C_IP4 = 1;
  localparam int C_IP6 = 2;
  localparam int C_ARP = 3;
  localparam int C_ICMP = 4;
  localparam int C_TCP = 5;
  localparam int C_UDP = 6;
  localparam int C_BYTES = 7;

  localparam logic [15:0] ETH_HDR = 16'd14;
  localparam logic [15:0] IP4_MIN = 16'd34;
  localparam logic [15:0] IP6_MIN = 16'd54;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] ETYPE_ARP = 16'h0806;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_ICMPV6 = 8'd58;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // 8 * sum > 1024 * kbps is sum > kbps * 128.
  localparam int ALERT_SHIFT = $clog2(1024 / 8);

  typedef enum logic [1:0] {
    OP_PACKET = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_PORTS = 2'd0,
    REG_ALERT = 2'd1,
    REG_DURATION = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PKT,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_WALK_RD,
    ST_WALK_OUT
  } state_t;

  typedef logic [NCNT-1:0][CTR_W-1:0] cnt_row_t;

  typedef struct packed {
    logic ip4;
    logic ip6;
    logic arp;
    logic icmp;
    logic tcp;
    logic udp;
  } pkt_inc_t;

  typedef struct packed {
    logic [2:0] port;
    cnt_row_t cnt;
    logic alert;
    logic done;
    logic last;
  } result_t;

endpackage

// File: design/epc_ram.sv
module epc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/epc_classify.sv
module epc_classify (
  input  logic [15:0]       captured_length,
  input  logic [15:0]       frame_ethertype,
  input  logic [7:0]        ipv4_protocol,
  input  logic [7:0]        ipv6_next_header,
  output epc_pkg::pkt_inc_t inc
);
  import epc_pkg::*;

  logic       l4_ok;
  logic [7:0] proto;
  logic [7:0] icmp_code;

  always_comb begin
    inc = '0;
    inc.ip4 = (frame_ethertype == ETYPE_IPV4);
    inc.ip6 = (frame_ethertype == ETYPE_IPV6);
    inc.arp = (frame_ethertype == ETYPE_ARP);
    l4_ok = (inc.ip4 && captured_length >= IP4_MIN) ||
            (inc.ip6 && captured_length >= IP6_MIN);
    proto = inc.ip4 ? ipv4_protocol : ipv6_next_header;
    icmp_code = inc.ip4 ? PROTO_ICMP : PROTO_ICMPV6;
    inc.icmp = l4_ok && (proto == icmp_code);
    inc.tcp = l4_ok && (proto == PROTO_TCP);
    inc.udp = l4_ok && (proto == PROTO_UDP);
  end

endmodule

// File: design/ethernet_protocol_counter_core.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    operation, port, lengths, ethertype, protocols
// out      output     out_valid / out_ready  report_port, eight counters, alert, done, last
// cfg      input      cfg_wr_en              cfg_index, cfg_data
//
// A packet is a read and a write-back of its port's row in the interval memory; an ignored
// packet is taken in idle with no memory access, as is clear all.
// An interval tick for n active ports first sums the byte counts through the interval memory
// read port, then walks the ports. Read totals walks the ports only.
// Reset is synchronous; per-row valid bits make both memories read as zero after reset.
// A stalled output holds the walk in place; the input is taken only when idle.
module ethernet_protocol_counter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [2:0]  in_port,
  input  logic [15:0] in_captured_length,
  input  logic [15:0] in_wire_length,
  input  logic [15:0] in_frame_ethertype,
  input  logic [7:0]  in_ipv4_protocol,
  input  logic [7:0]  in_ipv6_next_header,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_report_port,
  output logic [31:0] out_packets_all,
  output logic [31:0] out_packets_ipv4,
  output logic [31:0] out_packets_ipv6,
  output logic [31:0] out_packets_arp,
  output logic [31:0] out_packets_icmp,
  output logic [31:0] out_packets_tcp,
  output logic [31:0] out_packets_udp,
  output logic [31:0] out_byte_count,
  output logic        out_bandwidth_alert,
  output logic        out_duration_done,
  output logic        out_last_report,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [21:0] cfg_data
);
  import epc_pkg::*;

  state_t   state_r, state_nxt;
  op_t      op_r, op_nxt;
  logic [2:0]  port_r, port_nxt;
  logic [15:0] wire_r, wire_nxt;
  pkt_inc_t inc_r, inc_nxt, inc_in;
  logic [PORT_W-1:0] idx_r, idx_nxt;
  logic [CTR_W-1:0] sum_r, sum_nxt;
  logic alert_r, alert_nxt;
  logic done_r, done_nxt;
  logic [15:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [MAX_PORTS-1:0] ival_v_r, ival_v_nxt;
  logic [MAX_PORTS-1:0] tot_v_r, tot_v_nxt;
  result_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [3:0]  ports_cfg_r;
  logic [21:0] alert_kbps_r;
  logic [15:0] duration_r;

  logic [CNT_W-1:0] n_act;
  logic [CNT_W-1:0] n_last;
  logic is_last;
  logic in_fire;
  logic pkt_take;
  logic load_out;

  logic              ival_we, ival_re, tot_we, tot_re;
  logic [PORT_W-1:0] ival_waddr, ival_raddr, tot_addr;
  cnt_row_t          ival_wdata, tot_wdata, ival_rdata, tot_rdata;
  cnt_row_t          ival_row, tot_row;

  epc_classify u_classify (
    .captured_length  (in_captured_length),
    .frame_ethertype  (in_frame_ethertype),
    .ipv4_protocol    (in_ipv4_protocol),
    .ipv6_next_header (in_ipv6_next_header),
    .inc              (inc_in)
  );

  epc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_PORTS)) u_ival_ram (
    .clk     (clk),
    .wr_en   (ival_we),
    .wr_addr (ival_waddr),
    .wr_data (ival_wdata),
    .rd_en   (ival_re),
    .rd_addr (ival_raddr),
    .rd_data (ival_rdata)
  );

  epc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_PORTS)) u_tot_ram (
    .clk     (clk),
    .wr_en   (tot_we),
    .wr_addr (tot_addr),
    .wr_data (tot_wdata),
    .rd_en   (tot_re),
    .rd_addr (tot_addr),
    .rd_data (tot_rdata)
  );

  always_comb begin
    if (ports_cfg_r == '0) begin
      n_act = CNT_W'(1);
    end else if (ports_cfg_r > 4'(MAX_ACTIVE)) begin
      n_act = CNT_W'(MAX_ACTIVE);
    end else begin
      n_act = CNT_W'(ports_cfg_r);
    end
  end

  assign n_last = n_act - CNT_W'(1);
  assign is_last = (CNT_W'(idx_r) == n_last);
  assign in_fire = in_valid && in_ready;
  assign pkt_take = (CNT_W'(in_port) < n_act) && (in_captured_length >= ETH_HDR);
  assign elapsed_inc = elapsed_r + 16'd1;
  assign ival_row = ival_v_r[idx_r] ? ival_rdata : '0;
  assign tot_row = tot_v_r[idx_r] ? tot_rdata : '0;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    port_nxt = port_r;
    wire_nxt = wire_r;
    inc_nxt = inc_r;
    idx_nxt = idx_r;
    sum_nxt = sum_r;
    alert_nxt = alert_r;
    done_nxt = done_r;
    elapsed_nxt = elapsed_r;
    ival_v_nxt = ival_v_r;
    tot_v_nxt = tot_v_r;
    out_nxt = out_r;
    in_ready = 1'b0;
    load_out = 1'b0;
    ival_we = 1'b0;
    ival_re = 1'b0;
    ival_waddr = idx_r;
    ival_raddr = idx_r;
    ival_wdata = '0;
    tot_we = 1'b0;
    tot_re = 1'b0;
    tot_addr = idx_r;
    tot_wdata = '0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt = op_t'(in_operation);
          port_nxt = in_port;
          wire_nxt = in_wire_length;
          inc_nxt = inc_in;
          idx_nxt = '0;
          unique case (op_t'(in_operation))
            OP_PACKET: begin
              if (pkt_take) begin
                ival_re = 1'b1;
                ival_raddr = PORT_W'(in_port);
                state_nxt = ST_PKT;
              end
            end
            OP_TICK: begin
              elapsed_nxt = elapsed_inc;
              done_nxt = (duration_r != '0) && (elapsed_inc >= duration_r);
              sum_nxt = '0;
              state_nxt = ST_SUM_RD;
            end
            OP_READ: begin
              alert_nxt = 1'b0;
              done_nxt = 1'b0;
              state_nxt = ST_WALK_RD;
            end
            OP_CLEAR: begin
              ival_v_nxt = '0;
              tot_v_nxt = '0;
              elapsed_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_PKT: begin
        ival_we = 1'b1;
        ival_waddr = PORT_W'(port_r);
        ival_wdata = ival_v_r[PORT_W'(port_r)] ? ival_rdata : '0;
        ival_wdata[C_ALL] = ival_wdata[C_ALL] + CTR_W'(1);
        ival_wdata[C_IP4] = ival_wdata[C_IP4] + CTR_W'(inc_r.ip4);
        ival_wdata[C_IP6] = ival_wdata[C_IP6] + CTR_W'(inc_r.ip6);
        ival_wdata[C_ARP] = ival_wdata[C_ARP] + CTR_W'(inc_r.arp);
        ival_wdata[C_ICMP] = ival_wdata[C_ICMP] + CTR_W'(inc_r.icmp);
        ival_wdata[C_TCP] = ival_wdata[C_TCP] + CTR_W'(inc_r.tcp);
        ival_wdata[C_UDP] = ival_wdata[C_UDP] + CTR_W'(inc_r.udp);
        ival_wdata[C_BYTES] = ival_wdata[C_BYTES] + CTR_W'(wire_r);
        ival_v_nxt[PORT_W'(port_r)] = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SUM_RD: begin
        ival_re = 1'b1;
        state_nxt = ST_SUM_ACC;
      end
      ST_SUM_ACC: begin
        sum_nxt = sum_r + ival_row[C_BYTES];
        if (is_last) begin
          alert_nxt = (alert_kbps_r != '0) &&
                      (sum_nxt > (CTR_W'(alert_kbps_r) << ALERT_SHIFT));
          idx_nxt = '0;
          state_nxt = ST_WALK_RD;
        end else begin
          idx_nxt = idx_r + PORT_W'(1);
          state_nxt = ST_SUM_RD;
        end
      end
      ST_WALK_RD: begin
        ival_re = (op_r == OP_TICK);
        tot_re = 1'b1;
        state_nxt = ST_WALK_OUT;
      end
      ST_WALK_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out = 1'b1;
          out_nxt.port = 3'(idx_r);
          out_nxt.alert = alert_r;
          out_nxt.done = done_r;
          out_nxt.last = is_last;
          if (op_r == OP_TICK) begin
            out_nxt.cnt = ival_row;
            tot_we = 1'b1;
            for (int k = 0; k < NCNT; k++) begin
              tot_wdata[k] = tot_row[k] + ival_row[k];
            end
            tot_v_nxt[idx_r] = 1'b1;
            ival_v_nxt[idx_r] = 1'b0;
          end else begin
            out_nxt.cnt = tot_row;
          end
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + PORT_W'(1);
            state_nxt = ST_WALK_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r <= '0;
      elapsed_r <= '0;
      ival_v_r <= '0;
      tot_v_r <= '0;
      out_valid_r <= 1'b0;
      alert_r <= 1'b0;
      done_r <= 1'b0;
      sum_r <= '0;
      op_r <= OP_PACKET;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      elapsed_r <= elapsed_nxt;
      ival_v_r <= ival_v_nxt;
      tot_v_r <= tot_v_nxt;
      out_valid_r <= out_valid_nxt;
      alert_r <= alert_nxt;
      done_r <= done_nxt;
      sum_r <= sum_nxt;
      op_r <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    port_r <= port_nxt;
    wire_r <= wire_nxt;
    inc_r <= inc_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ports_cfg_r <= 4'd1;
      alert_kbps_r <= '0;
      duration_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PORTS: ports_cfg_r <= cfg_data[3:0];
        REG_ALERT: alert_kbps_r <= cfg_data;
        REG_DURATION: duration_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_report_port = out_r.port;
  assign out_packets_all = out_r.cnt[C_ALL];
  assign out_packets_ipv4 = out_r.cnt[C_IP4];
  assign out_packets_ipv6 = out_r.cnt[C_IP6];
  assign out_packets_arp = out_r.cnt[C_ARP];
  assign out_packets_icmp = out_r.cnt[C_ICMP];
  assign out_packets_tcp = out_r.cnt[C_TCP];
  assign out_packets_udp = out_r.cnt[C_UDP];
  assign out_byte_count = out_r.cnt[C_BYTES];
  assign out_bandwidth_alert = out_r.alert;
  assign out_duration_done = out_r.done;
  assign out_last_report = out_r.last;

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK_OUT || state_r == ST_SUM_ACC) |-> (CNT_W'(idx_r) < n_act))
    else $error("port walk went past the active ports");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && is_last) |=> (state_r == ST_IDLE))
    else $error("walk did not end after the last report");

  a_tick_clears_row: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && op_r == OP_TICK) |=> !ival_v_r[$past(idx_r)])
    else $error("tick left an interval row valid");

  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_operation == OP_CLEAR) |=>
      (elapsed_r == '0 && ival_v_r == '0 && tot_v_r == '0))
    else $error("clear all left state behind");

endmodule
